/* src/psi_pkg.sv */
// Shared types for the pairwise segment intersection block.
package psi_pkg;

   // Sequencer states of the pair walk
   typedef enum logic [3:0] {
      S_IDLE,
      S_RDI,
      S_LATI,
      S_RDJ,
      S_LATJ,
      S_DIFF,
      S_MUL,
      S_SUB,
      S_TEST,
      S_MPT,
      S_PREP,
      S_DIV,
      S_EMIT,
      S_NEXT,
      S_END
   } state_type;

   // Number of cross products formed for one pair
   localparam int unsigned NUM_PRODUCTS = 6;

endpackage

/* src/psi_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module psi_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/psi_div.sv */
// Restoring divider, one quotient bit per cycle, for quotients below 2**QW.
module psi_div #(
   parameter int NW = 54,
   parameter int QW = 18
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [NW-1:0] dsr,
   output logic [QW-1:0] quot,
   output logic          done
);

   localparam int CNTW = $clog2(QW + 1);

   logic [NW-1:0]   rem_ff, rem_in;
   logic [NW-1:0]   dsh_ff, dsh_in;
   logic [QW-1:0]   quot_ff, quot_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic            ge;

   assign ge = rem_ff >= dsh_ff;

   // Load on start, then subtract the shifted divisor where it fits
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         dsh_in  = dsr << (QW - 1);
         quot_in = '0;
         cnt_in  = CNTW'(QW);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[QW-2:0], ge};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

/* src/pairwise_segment_intersection.sv */
// Top level: segment store, pair walk sequencer and intersection datapath.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  request  | req_start_x .. req_end_of_set  | taken when start && !busy
//  result   | rsp_found .. rsp_last_result   | rsp_valid, one cycle, no stall
//
// A request without end_of_set stores its segment (or sets the drop flag when full) and leaves busy low.
// An end_of_set request walks all pairs: each pair reads both segments, forms
// the differences and the cross products on the shared multiplier and tests
// them; each hit then takes the two rounding divisions on the serial divider;
// the end marker follows the last pair.
// Reset empties the store at once (count and drop flag cleared), no sweep.
// The receiver cannot stall; every result is shown for exactly one cycle.
module pairwise_segment_intersection
   import psi_pkg::*;
#(
   parameter int MAX_SEGMENTS = 8,
   parameter int COORD_WIDTH  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   input  logic                          req_end_of_set,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic signed [15:0]            rsp_point_x,
   output logic signed [15:0]            rsp_point_y,
   output logic [2:0]                    rsp_first_index,
   output logic [2:0]                    rsp_second_index,
   output logic                          rsp_overflow,
   output logic                          rsp_last_result
);

   localparam int W    = COORD_WIDTH;
   localparam int AW   = $clog2(MAX_SEGMENTS);
   localparam int CW   = $clog2(MAX_SEGMENTS + 1);
   localparam int DW   = W + 1;
   localparam int PRW  = 2 * W + 2;
   localparam int SW   = 2 * W + 3;
   localparam int MW   = DW + SW;
   localparam int NW   = 3 * W + 6;
   localparam int QW   = W + 2;
   localparam int RW   = (W + 3 > 16) ? W + 3 : 16;
   localparam int STW  = $clog2(NUM_PRODUCTS);

   state_type state_ff, state_in;

   logic [CW-1:0]  count_ff;
   logic           dropped_ff;
   logic [CW-1:0]  i_ff, j_ff;
   logic [STW-1:0] step_ff;
   logic           axis_ff;
   logic           neg_ff;

   logic signed [W-1:0]   si_x_ff, si_y_ff, ei_x_ff, ei_y_ff;
   logic signed [W-1:0]   sj_x_ff, sj_y_ff, ej_x_ff, ej_y_ff;
   logic signed [DW-1:0]  ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [PRW-1:0] prod_ff [NUM_PRODUCTS];
   logic signed [SW-1:0]  den_ff, na_ff, nb_ff;
   logic signed [MW-1:0]  big_ff;
   logic signed [15:0]    px_ff;

   logic                  rsp_valid_ff, rsp_found_ff, rsp_overflow_ff, rsp_last_ff;
   logic signed [15:0]    rsp_x_ff, rsp_y_ff;
   logic [2:0]            rsp_i_ff, rsp_j_ff;

   logic                  accept;
   logic                  has_room;
   logic [CW-1:0]         count_after;
   logic                  ram_wr;
   logic [AW-1:0]         rd_addr;
   logic [4*W-1:0]        rd_data;
   logic signed [DW-1:0]  mul_a;
   logic signed [SW-1:0]  mul_b;
   logic signed [MW-1:0]  mul_p;
   logic                  div_start;
   logic                  div_done;
   logic [QW-1:0]         quot;
   logic [MW-1:0]         mag;
   logic [NW-1:0]         div_num, div_dsr;
   logic                  hit;
   logic                  more_j, more_i;
   logic signed [RW-1:0]  q_signed, pt_sum;
   logic signed [SW-1:0]  den_raw, na_raw, nb_raw;

   assign busy        = state_ff != S_IDLE;
   assign accept      = start && !busy;
   assign has_room    = count_ff < CW'(MAX_SEGMENTS);
   assign count_after = has_room ? count_ff + 1'b1 : count_ff;
   assign ram_wr      = accept && has_room;

   assign more_j = ({1'b0, j_ff} + 1'b1) < {1'b0, count_ff};
   assign more_i = ({1'b0, i_ff} + 2'd2) < {1'b0, count_ff};

   // Segment store: {start_x, start_y, end_x, end_y}
   psi_ram #(
      .WIDTH(4 * W),
      .DEPTH(MAX_SEGMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_start_x, req_start_y, req_end_x, req_end_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Rounding division: (2|n| + den) / (2 den)
   assign mag     = neg_ff ? MW'(-big_ff) : MW'(big_ff);
   assign div_num = (NW'(mag) << 1) + NW'($unsigned(den_ff));
   assign div_dsr = NW'($unsigned(den_ff)) << 1;

   psi_div #(
      .NW(NW),
      .QW(QW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .dsr   (div_dsr),
      .quot  (quot),
      .done  (div_done)
   );

   // Shared multiplier
   assign mul_p = mul_a * mul_b;

   // Cross-product differences and sign fix of the determinants
   assign den_raw = SW'(prod_ff[0]) - SW'(prod_ff[1]);
   assign na_raw  = SW'(prod_ff[2]) - SW'(prod_ff[3]);
   assign nb_raw  = SW'(prod_ff[4]) - SW'(prod_ff[5]);

   assign hit = (den_ff != '0) && (na_ff >= 0) && (na_ff <= den_ff)
                && (nb_ff >= 0) && (nb_ff <= den_ff);

   // Point coordinate: start plus signed rounded quotient
   assign q_signed = RW'(signed'({1'b0, quot}));
   assign pt_sum   = (axis_ff ? RW'(si_y_ff) : RW'(si_x_ff))
                     + (neg_ff ? -q_signed : q_signed);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_end_of_set) begin
               state_in = (count_after < CW'(2)) ? S_END : S_RDI;
            end
         end
         S_RDI:  state_in = S_LATI;
         S_LATI: state_in = S_LATJ;
         S_RDJ:  state_in = S_LATJ;
         S_LATJ: state_in = S_DIFF;
         S_DIFF: state_in = S_MUL;
         S_MUL: begin
            if (step_ff == STW'(NUM_PRODUCTS - 1)) begin
               state_in = S_SUB;
            end
         end
         S_SUB:  state_in = S_TEST;
         S_TEST: state_in = hit ? S_MPT : S_NEXT;
         S_MPT:  state_in = S_PREP;
         S_PREP: state_in = S_DIV;
         S_DIV: begin
            if (div_done) begin
               state_in = axis_ff ? S_EMIT : S_MPT;
            end
         end
         S_EMIT: state_in = S_NEXT;
         S_NEXT: begin
            if (more_j) begin
               state_in = S_RDJ;
            end else if (more_i) begin
               state_in = S_RDI;
            end else begin
               state_in = S_END;
            end
         end
         S_END:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer: read address, multiplier operands, divider start
   always_comb begin
      rd_addr   = j_ff[AW-1:0];
      mul_a     = ax_ff;
      mul_b     = SW'(by_ff);
      div_start = 1'b0;
      unique case (state_ff)
         S_RDI: rd_addr = i_ff[AW-1:0];
         S_MUL: begin
            case (step_ff)
               STW'(0): begin mul_a = ay_ff; mul_b = SW'(bx_ff); end
               STW'(1): begin mul_a = ax_ff; mul_b = SW'(by_ff); end
               STW'(2): begin mul_a = by_ff; mul_b = SW'(cx_ff); end
               STW'(3): begin mul_a = bx_ff; mul_b = SW'(cy_ff); end
               STW'(4): begin mul_a = ax_ff; mul_b = SW'(cy_ff); end
               default: begin mul_a = ay_ff; mul_b = SW'(cx_ff); end
            endcase
         end
         S_MPT: begin
            mul_a = axis_ff ? ay_ff : ax_ff;
            mul_b = na_ff;
         end
         S_PREP: div_start = 1'b1;
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_EMIT) || (state_ff == S_END);
         if (accept) begin
            count_ff <= count_after;
            if (!has_room) begin
               dropped_ff <= 1'b1;
            end
         end
         if (state_ff == S_END) begin
            count_ff   <= '0;
            dropped_ff <= 1'b0;
         end
      end
   end

   // Datapath and loop registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            i_ff <= '0;
            j_ff <= CW'(1);
         end
         S_LATI: {si_x_ff, si_y_ff, ei_x_ff, ei_y_ff} <= rd_data;
         S_LATJ: {sj_x_ff, sj_y_ff, ej_x_ff, ej_y_ff} <= rd_data;
         S_DIFF: begin
            ax_ff   <= DW'(ei_x_ff) - DW'(si_x_ff);
            ay_ff   <= DW'(ei_y_ff) - DW'(si_y_ff);
            bx_ff   <= DW'(sj_x_ff) - DW'(ej_x_ff);
            by_ff   <= DW'(sj_y_ff) - DW'(ej_y_ff);
            cx_ff   <= DW'(si_x_ff) - DW'(sj_x_ff);
            cy_ff   <= DW'(si_y_ff) - DW'(sj_y_ff);
            step_ff <= '0;
         end
         S_MUL: begin
            prod_ff[step_ff] <= mul_p[PRW-1:0];
            step_ff          <= step_ff + 1'b1;
         end
         S_SUB: begin
            den_ff <= (den_raw < 0) ? -den_raw : den_raw;
            na_ff  <= (den_raw < 0) ? -na_raw  : na_raw;
            nb_ff  <= (den_raw < 0) ? -nb_raw  : nb_raw;
         end
         S_TEST: axis_ff <= 1'b0;
         S_MPT: begin
            big_ff <= mul_p;
            neg_ff <= mul_p < 0;
         end
         S_DIV: begin
            if (div_done) begin
               if (axis_ff) begin
                  rsp_y_ff <= pt_sum[15:0];
               end else begin
                  px_ff <= pt_sum[15:0];
               end
               axis_ff <= 1'b1;
            end
         end
         S_EMIT: begin
            rsp_found_ff    <= 1'b1;
            rsp_x_ff        <= px_ff;
            rsp_i_ff        <= 3'(i_ff);
            rsp_j_ff        <= 3'(j_ff);
            rsp_overflow_ff <= 1'b0;
            rsp_last_ff     <= 1'b0;
         end
         S_NEXT: begin
            if (more_j) begin
               j_ff <= j_ff + 1'b1;
            end else begin
               i_ff <= i_ff + 1'b1;
               j_ff <= i_ff + CW'(2);
            end
         end
         S_END: begin
            rsp_found_ff    <= 1'b0;
            rsp_x_ff        <= '0;
            rsp_y_ff        <= '0;
            rsp_i_ff        <= '0;
            rsp_j_ff        <= '0;
            rsp_overflow_ff <= dropped_ff;
            rsp_last_ff     <= 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_point_x      = rsp_x_ff;
   assign rsp_point_y      = rsp_y_ff;
   assign rsp_first_index  = rsp_i_ff;
   assign rsp_second_index = rsp_j_ff;
   assign rsp_overflow     = rsp_overflow_ff;
   assign rsp_last_result  = rsp_last_ff;

endmodule

/* src/psi_checker.sv */
// Port-level checks on the pairwise segment intersection block, bound to the top.
module psi_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_end_of_set,
   input logic rsp_valid,
   input logic rsp_found,
   input logic rsp_overflow,
   input logic rsp_last_result
);

   // A request that closes the set starts the pair walk
   a_eos_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_end_of_set |=> busy)
      else $error("end of set did not start the pair walk");

   // The end marker carries no point
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |-> !rsp_found)
      else $error("end marker flagged as a point");

   // Point results carry no overflow and are not last
   a_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> !rsp_overflow && !rsp_last_result)
      else $error("point result with marker flags");

   // Points appear only while the walk runs
   a_point_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> busy)
      else $error("point result outside a pair walk");

   // Nothing follows the end marker in the next cycle
   a_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |=> !rsp_valid)
      else $error("result right after end marker");

endmodule

bind pairwise_segment_intersection psi_checker u_psi_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_end_of_set  (req_end_of_set),
   .rsp_valid       (rsp_valid),
   .rsp_found       (rsp_found),
   .rsp_overflow    (rsp_overflow),
   .rsp_last_result (rsp_last_result)
);

/* test/tb_pairwise_segment_intersection.sv */
// Testbench for the pairwise segment intersection block: random and directed segment sets.
`timescale 1ns / 100ps

module tb_pairwise_segment_intersection;
   import psi_pkg::*;

   localparam int MAX_SEG = 8;
   localparam int CW = 16;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct {
      logic              found;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic [2:0]        fi;
      logic [2:0]        si;
      logic              ovf;
      logic              last;
   } point_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [CW-1:0] req_start_x = 0, req_start_y = 0, req_end_x = 0, req_end_y = 0;
   logic req_end_of_set = 0;
   logic rsp_valid, rsp_found, rsp_overflow, rsp_last_result;
   logic signed [15:0] rsp_point_x, rsp_point_y;
   logic [2:0] rsp_first_index, rsp_second_index;

   pairwise_segment_intersection u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y), .req_end_of_set(req_end_of_set),
      .rsp_valid(rsp_valid), .rsp_found(rsp_found), .rsp_point_x(rsp_point_x),
      .rsp_point_y(rsp_point_y), .rsp_first_index(rsp_first_index),
      .rsp_second_index(rsp_second_index), .rsp_overflow(rsp_overflow),
      .rsp_last_result(rsp_last_result)
   );

   always #10 clock = ~clock;

   // predictor state
   longint    seg_sx[MAX_SEG], seg_sy[MAX_SEG], seg_ex[MAX_SEG], seg_ey[MAX_SEG];
   int        seg_count = 0;
   bit        seg_dropped = 0;
   point_type expected_points[$];
   int        errors = 0;
   int        send_gap_pct = 0;
   longint    cycles = 0;

   function automatic longint round_div(longint n, longint d);
      longint un, q;
      un = (n < 0) ? -n : n;
      q = (2 * un + d) / (2 * d);
      return (n < 0) ? -q : q;
   endfunction

   // predict the results of one request
   task automatic predict_segment(longint sx, longint sy, longint ex, longint ey, bit eos);
      longint ax, ay, bx, by, cx, cy, den, na, nb;
      point_type p;
      if (seg_count < MAX_SEG) begin
         seg_sx[seg_count] = sx; seg_sy[seg_count] = sy;
         seg_ex[seg_count] = ex; seg_ey[seg_count] = ey;
         seg_count++;
      end else begin
         seg_dropped = 1;
      end
      if (!eos) return;
      for (int i = 0; i < seg_count; i++) begin
         for (int j = i + 1; j < seg_count; j++) begin
            ax = seg_ex[i] - seg_sx[i]; ay = seg_ey[i] - seg_sy[i];
            bx = seg_sx[j] - seg_ex[j]; by = seg_sy[j] - seg_ey[j];
            cx = seg_sx[i] - seg_sx[j]; cy = seg_sy[i] - seg_sy[j];
            den = ay * bx - ax * by;
            na = by * cx - bx * cy;
            nb = ax * cy - ay * cx;
            if (den == 0) continue;
            if (den < 0) begin
               den = -den; na = -na; nb = -nb;
            end
            if (na < 0 || na > den || nb < 0 || nb > den) continue;
            p.found = 1;
            p.px = 16'(seg_sx[i] + round_div(ax * na, den));
            p.py = 16'(seg_sy[i] + round_div(ay * na, den));
            p.fi = 3'(i); p.si = 3'(j); p.ovf = 0; p.last = 0;
            expected_points = {expected_points, p};
         end
      end
      p = '{found: 0, px: 0, py: 0, fi: 0, si: 0, ovf: seg_dropped, last: 1};
      expected_points = {expected_points, p};
      seg_count = 0;
      seg_dropped = 0;
   endtask

   // send one request, idling at random first
   task automatic send_segment(logic signed [CW-1:0] sx, sy, ex, ey, bit eos);
      while ($urandom_range(99) < send_gap_pct) begin
         start <= 0;
         @(negedge clock);
      end
      req_start_x <= sx; req_start_y <= sy; req_end_x <= ex; req_end_y <= ey;
      req_end_of_set <= eos;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_segment(sx, sy, ex, ey, eos);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 0;
      @(negedge clock);
      while (expected_points.size() != 0) @(negedge clock);
   endtask

   // check each result against the oldest expectation
   always @(posedge clock) begin
      point_type e;
      cycles++;
      if (!reset && rsp_valid) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected result found=%0d x=%0d y=%0d", $time, rsp_found,
                     rsp_point_x, rsp_point_y);
            errors++;
         end else begin
            e = expected_points.pop_front();
            if (rsp_found !== e.found || rsp_point_x !== e.px || rsp_point_y !== e.py ||
                rsp_first_index !== e.fi || rsp_second_index !== e.si ||
                rsp_overflow !== e.ovf || rsp_last_result !== e.last) begin
               $display("%0t: mismatch expected f=%0d x=%0d y=%0d i=%0d j=%0d o=%0d l=%0d",
                        $time, e.found, e.px, e.py, e.fi, e.si, e.ovf, e.last);
               $display("%0t:          actual f=%0d x=%0d y=%0d i=%0d j=%0d o=%0d l=%0d",
                        $time, rsp_found, rsp_point_x, rsp_point_y, rsp_first_index,
                        rsp_second_index, rsp_overflow, rsp_last_result);
               errors++;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic signed [CW-1:0] rand_coord(int mode);
      case (mode)
         0: return CW'($urandom);
         1: return CW'($signed($urandom_range(200)) - 100);
         default: return CW'($signed($urandom_range(4000)) - 2000);
      endcase
   endfunction

   // extremes, parallel, zero-length, touching ends, ties, single-segment and full sets
   task automatic test_directed();
      send_segment(0, 0, 0, 0, 1);                       // single segment set
      send_segment(-32768, -32768, 32767, 32767, 0);
      send_segment(-32768, 32767, 32767, -32768, 0);
      send_segment(0, 0, 0, 0, 0);                       // zero length
      send_segment(-32768, -32767, 32767, 32766, 1);     // nearly parallel to first
      send_segment(0, 0, 16, 0, 0);
      send_segment(16, 0, 16, 16, 0);                    // touching ends
      send_segment(0, 1, 3, 2, 0);
      send_segment(1, 0, 1, 5, 1);                       // rounding tie region
      for (int k = 0; k < 10; k++)                       // overflow, eos dropped
         send_segment(CW'(k * 3 - 10), -20, CW'(10 - k * 2), 20, k == 9);
      wait_drained();
   endtask

   task automatic test_random(int n_items);
      int mode, left;
      left = n_items;
      while (left > 0) begin
         int n_set;
         mode = $urandom_range(2);
         n_set = ($urandom_range(9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
         for (int k = 0; k < n_set; k++) begin
            send_segment(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                         rand_coord(mode), k == n_set - 1);
            left--;
         end
         if ($urandom_range(15) == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_gap_pct = 27;
      test_directed();
      test_random(150);
      send_gap_pct = 65;
      test_random(150);
      send_gap_pct = 0;
      test_random(150);
      wait_drained();
      repeat (100) @(negedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
